// ===== hdl/transposition_table_probe_record_top_macros.svh =====
// Assertion macros shared by the transposition table modules.
`ifndef TRANSPOSITION_TABLE_PROBE_RECORD_TOP_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_RECORD_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TTPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TTPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ttpr_pkg.sv =====
// Types, constants and codes of the transposition table block.
package ttpr_pkg;

  localparam int TABLE_ENTRIES_DFLT = 65536;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_ADDR_W         = 3;

  localparam logic [14:0] MATE_SCORE_RST    = 15'd10000;
  localparam logic [14:0] WIN_THRESHOLD_RST = 15'd9900;

  // Register indexes, taken from paddr[2].
  localparam logic REG_MATE_SCORE    = 1'b0;
  localparam logic REG_WIN_THRESHOLD = 1'b1;

  // Bound kinds held in an entry.
  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  typedef enum logic {
    OP_PROBE  = 1'b0,
    OP_RECORD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_state_t;

  typedef struct packed {
    logic [14:0] mate_score;
    logic [14:0] win_threshold;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        position_key;
    logic [31:0]        check_word_a;
    logic [31:0]        check_word_b;
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
    logic signed [7:0]  remaining_depth;
    logic [6:0]         ply_distance;
    logic signed [15:0] record_score;
    logic [1:0]         record_kind;
    logic [15:0]        record_move;
  } item_t;

  typedef struct packed {
    logic [31:0]        lock_a;
    logic [31:0]        lock_b;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic signed [7:0]  depth;
    logic [1:0]         kind;
  } entry_t;

  // Back end to front end control.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ttpr_if.sv =====
// Valid/ready channel interfaces for input items and probe results.
interface ttpr_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [31:0]        position_key;
  logic [31:0]        check_word_a;
  logic [31:0]        check_word_b;
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;
  logic signed [7:0]  remaining_depth;
  logic [6:0]         ply_distance;
  logic signed [15:0] record_score;
  logic [1:0]         record_kind;
  logic [15:0]        record_move;

  modport source (
    output valid, mode, position_key, check_word_a, check_word_b, lower_bound,
           upper_bound, remaining_depth, ply_distance, record_score, record_kind,
           record_move,
    input  ready
  );
  modport sink (
    input  valid, mode, position_key, check_word_a, check_word_b, lower_bound,
           upper_bound, remaining_depth, ply_distance, record_score, record_kind,
           record_move,
    output ready
  );
endinterface

interface ttpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] probe_score;
  logic               score_usable;
  logic [15:0]        hash_move;

  modport source (output valid, probe_score, score_usable, hash_move, input ready);
  modport sink (input valid, probe_score, score_usable, hash_move, output ready);
endinterface

// ===== hdl/ttpr_cfg.sv =====
// APB-style configuration registers for mate score and win threshold.
module ttpr_cfg import ttpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        REG_MATE_SCORE:    cfg_nxt.mate_score    = pwdata[14:0];
        REG_WIN_THRESHOLD: cfg_nxt.win_threshold = pwdata[14:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mate_score    <= MATE_SCORE_RST;
      cfg_r.win_threshold <= WIN_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MATE_SCORE:    prdata = {17'd0, cfg_r.mate_score};
      REG_WIN_THRESHOLD: prdata = {17'd0, cfg_r.win_threshold};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/ttpr_front.sv =====
// Front end: accepts input transactions, decodes the operation and queues them.
`include "transposition_table_probe_record_top_macros.svh"

module ttpr_front import ttpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ttpr_in_if.sink    in_ch,
  input  back_ctl_t  ctl,
  output logic       item_valid,
  output item_t      item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  item_t            in_item;

  assign in_ch.ready = (count_r != CNT_W'(QUEUE_DEPTH)) && !ctl.clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = ctl.pop;

  always_comb begin
    in_item.op              = in_ch.mode ? OP_RECORD : OP_PROBE;
    in_item.position_key    = in_ch.position_key;
    in_item.check_word_a    = in_ch.check_word_a;
    in_item.check_word_b    = in_ch.check_word_b;
    in_item.lower_bound     = in_ch.lower_bound;
    in_item.upper_bound     = in_ch.upper_bound;
    in_item.remaining_depth = in_ch.remaining_depth;
    in_item.ply_distance    = in_ch.ply_distance;
    in_item.record_score    = in_ch.record_score;
    in_item.record_kind     = in_ch.record_kind;
    in_item.record_move     = in_ch.record_move;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_item;
    end
  end

  assign item_valid = (count_r != '0);
  assign item       = queue_r[rd_ptr_r];

  `TTPR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `TTPR_ASSERT_IMP(a_pop_nonempty, pop, count_r != '0, "pop from empty queue")
  `TTPR_ASSERT_NXT(a_push_grows, push && !pop, count_r == $past(count_r) + 1'b1,
                   "queue count did not grow on push")

endmodule

// ===== hdl/ttpr_back.sv =====
// Back end: table memory, clearing pass, probe evaluation and record write-back.
`include "transposition_table_probe_record_top_macros.svh"

module ttpr_back import ttpr_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        item_valid,
  input  item_t       item,
  output back_ctl_t   ctl,
  ttpr_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  entry_t             table_mem [TABLE_ENTRIES];
  entry_t             rd_data_r;
  item_t              cur_r;
  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;
  logic               rd_en;
  logic               out_load;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_score_r;
  logic               out_usable_r;
  logic [15:0]        out_move_r;

  logic signed [17:0] win18, ply18, miss18;
  logic signed [17:0] rec_s18, rec_adj;
  logic               stored_deeper;
  entry_t             new_entry;
  logic               lock_hit, mate_hi, mate_lo, depth_ok, kind_ok, ok;
  logic signed [17:0] st_s18, pr_adj;
  logic signed [15:0] probe_score;

  // Record path arithmetic.
  assign win18   = {3'b000, cfg.win_threshold};
  assign miss18  = -$signed({3'b000, cfg.mate_score});
  assign ply18   = {11'd0, cur_r.ply_distance};
  assign rec_s18 = 18'(cur_r.record_score);

  always_comb begin
    if (rec_s18 > win18) begin
      rec_adj = rec_s18 + ply18;
    end else if (rec_s18 < -win18) begin
      rec_adj = rec_s18 - ply18;
    end else begin
      rec_adj = rec_s18;
    end
  end

  assign stored_deeper = rd_data_r.depth > cur_r.remaining_depth;

  always_comb begin
    new_entry.lock_a = cur_r.check_word_a;
    new_entry.lock_b = cur_r.check_word_b;
    new_entry.score  = sat16(rec_adj);
    new_entry.move   = cur_r.record_move;
    new_entry.depth  = cur_r.remaining_depth;
    new_entry.kind   = cur_r.record_kind;
  end

  // Probe path: mate scores are pulled back toward zero by the ply distance.
  assign lock_hit = (rd_data_r.lock_a == cur_r.check_word_a) &&
                    (rd_data_r.lock_b == cur_r.check_word_b);
  assign st_s18   = 18'(rd_data_r.score);
  assign mate_hi  = st_s18 > win18;
  assign mate_lo  = st_s18 < -win18;

  always_comb begin
    if (mate_hi) begin
      pr_adj = st_s18 - ply18;
    end else if (mate_lo) begin
      pr_adj = st_s18 + ply18;
    end else begin
      pr_adj = st_s18;
    end
  end

  assign depth_ok = (rd_data_r.depth >= cur_r.remaining_depth) || mate_hi || mate_lo;

  always_comb begin
    case (rd_data_r.kind)
      KIND_LOWER: kind_ok = pr_adj >= 18'(cur_r.upper_bound);
      KIND_UPPER: kind_ok = pr_adj <= 18'(cur_r.lower_bound);
      default:    kind_ok = 1'b1;
    endcase
  end

  // A score at or below the miss sentinel would be indistinguishable from a miss.
  assign ok          = lock_hit && depth_ok && kind_ok && (pr_adj > miss18);
  assign probe_score = ok ? pr_adj[15:0] : miss18[15:0];

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    ctl.pop     = 1'b0;
    ctl.clearing = (state_r == ST_CLEAR);
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = clr_idx_r;
    mem_wd      = '0;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          ctl.pop   = 1'b1;
          rd_en     = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cur_r.op == OP_RECORD) begin
          mem_we    = !stored_deeper;
          mem_wa    = cur_r.position_key[IDX_W-1:0];
          mem_wd    = new_entry;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= table_mem[item.position_key[IDX_W-1:0]];
      cur_r     <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_score_r  <= probe_score;
      out_usable_r <= ok;
      out_move_r   <= lock_hit ? rd_data_r.move : 16'd0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.probe_score  = out_score_r;
  assign out_ch.score_usable = out_usable_r;
  assign out_ch.hash_move    = out_move_r;

  `TTPR_ASSERT_IMP(a_no_pop_clear, state_r == ST_CLEAR, !ctl.pop, "item taken during clear")
  `TTPR_ASSERT_NXT(a_pop_to_look, ctl.pop, state_r == ST_LOOK, "pop did not start a lookup")
  `TTPR_ASSERT_IMP(a_we_record, mem_we && state_r != ST_CLEAR, cur_r.op == OP_RECORD,
                   "table written by a probe")
  `TTPR_ASSERT_IMP(a_out_from_probe, $rose(out_valid_r), $past(state_r) == ST_LOOK,
                   "result raised outside a probe lookup")

endmodule

// ===== hdl/transposition_table_probe_record_top.sv =====
// Top level of the depth-preferred transposition table (probe and record).
//
// Items arrive on in_ch (valid/ready). mode 0 probes the table entry chosen by
// the low bits of position_key and yields one transaction on out_ch; mode 1
// records into that entry, unless the stored depth is greater, and yields none.
// Two registers on the APB-style port set the mate score and the win threshold;
// write them only while the block is idle.
//
// In the back end each item is read from the table into a register in ST_IDLE
// and evaluated in ST_LOOK, which writes back a record or loads the result
// register. A probe's result is offered on out_ch from that result register;
// the back end takes the next item only after it has finished the previous one.
// After reset the table is swept to zero, one entry a cycle, over all
// TABLE_ENTRIES entries; in_ch.ready stays low during that pass, configuration writes work.
// A two-entry queue sits between the input and the back end. When out_ch is
// stalled, records keep flowing and a probe waits in the back end holding the
// queue until the result register frees.
module transposition_table_probe_record_top import ttpr_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ttpr_in_if.sink               in_ch,
  ttpr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t      cfg;
  back_ctl_t ctl;
  logic      item_valid;
  item_t     item;

  ttpr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  ttpr_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .ctl        (ctl),
    .out_ch     (out_ch)
  );

endmodule
